### src/pba_pkg.sv
`timescale 1ns / 1ps

package pba_pkg;

  // grid geometry and cell storage
  localparam int GRID_W     = 64;
  localparam int GRID_H     = 64;
  localparam int MAX_RADIUS = 31;
  localparam int VALUE_BITS = 32;

  localparam int CELLS  = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int XI_W   = $clog2(GRID_W);
  localparam int YI_W   = $clog2(GRID_H);

  // field widths
  localparam int REQ_W     = 2;
  localparam int POS_W     = 8;
  localparam int R_W       = 5;
  localparam int DIM_W     = 7;
  localparam int OUT_VAL_W = 32;

  // squared distance and window coordinate widths
  localparam int SQ_W = 2 * R_W;
  localparam int CO_W = POS_W + 1;

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 7;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd2;

  // reset values of the configuration registers
  localparam logic [R_W-1:0]   RADIUS_RST = 5'd25;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 7'd64;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_BUMP  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic scan_step;
    logic clear_step;
    logic capture;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic clear_last;
    logic out_free;
  } sts_t;

  // row-major cell address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [YI_W-1:0] y,
                                                  input logic [XI_W-1:0] x);
    return ADDR_W'(y) * ADDR_W'(GRID_W) + ADDR_W'(x);
  endfunction

  // next square when an offset steps up by one: sq + 2*d + 1
  function automatic logic [SQ_W-1:0] sq_next(input logic [SQ_W-1:0] sq,
                                              input logic signed [R_W:0] d);
    logic [SQ_W+1:0] t;
    t = {2'b00, sq} + {{(SQ_W-R_W){d[R_W]}}, d, 1'b1};
    return t[SQ_W-1:0];
  endfunction

endpackage

### src/pba_ctrl.sv
`timescale 1ns / 1ps

module pba_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [pba_pkg::REQ_W-1:0] req_type,
  input  pba_pkg::sts_t            sts,
  output pba_pkg::cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_BOOT,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_READ_DATA,
    S_CLEAR,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   take;

  assign in_tready = (state_r == S_IDLE);
  assign take      = in_tvalid && (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_BOOT: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          unique case (pba_pkg::req_t'(req_type))
            pba_pkg::REQ_BUMP:  state_nxt = S_SCAN;
            pba_pkg::REQ_READ:  state_nxt = S_READ;
            pba_pkg::REQ_CLEAR: state_nxt = S_CLEAR;
            default:            state_nxt = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN:     state_nxt = S_RESP;
      S_READ:      state_nxt = S_READ_DATA;
      S_READ_DATA: state_nxt = S_RESP;
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.start      = take;
    cmd.scan_step  = (state_r == S_SCAN);
    cmd.clear_step = (state_r == S_BOOT) || (state_r == S_CLEAR);
    cmd.capture    = (state_r == S_READ_DATA);
    cmd.out_load   = (state_r == S_RESP) && sts.out_free;
  end

  // state register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/pba_dp.sv
`timescale 1ns / 1ps

module pba_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pba_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [pba_pkg::REQ_W-1:0]           req_type,
  input  logic signed [pba_pkg::POS_W-1:0]    pos_x,
  input  logic signed [pba_pkg::POS_W-1:0]    pos_y,
  input  pba_pkg::cmd_t                       cmd,
  output pba_pkg::sts_t                       sts,
  input  logic                                out_tready,
  output logic                                out_valid,
  output logic [pba_pkg::OUT_VAL_W-1:0]       out_value,
  output logic                                out_status
);

  localparam int R_W   = pba_pkg::R_W;
  localparam int SQ_W  = pba_pkg::SQ_W;
  localparam int CO_W  = pba_pkg::CO_W;
  localparam int POS_W = pba_pkg::POS_W;
  localparam int DIM_W = pba_pkg::DIM_W;
  localparam int VB    = pba_pkg::VALUE_BITS;
  localparam int AW    = pba_pkg::ADDR_W;

  // configuration registers
  logic [R_W-1:0]   radius_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  // clamped configuration
  logic [R_W-1:0]   r_eff;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // request and scan registers
  logic signed [POS_W-1:0] cx_r;
  logic signed [POS_W-1:0] cy_r;
  logic [R_W-1:0]          r_r;
  logic [SQ_W-1:0]         r2_r;
  logic signed [R_W:0]     dx_r;
  logic signed [R_W:0]     dy_r;
  logic [SQ_W-1:0]         dx2_r;
  logic [SQ_W-1:0]         dy2_r;
  logic [AW-1:0]           req_addr_r;

  // write stage of the read-modify-write pipe
  logic          p_valid_r;
  logic [AW-1:0] p_addr_r;
  logic [SQ_W-1:0] p_inc_r;

  // clearing sweep
  logic [AW-1:0] clr_addr_r;

  // cell store
  logic [VB-1:0] mem [pba_pkg::CELLS];
  logic [VB-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  // result hold and output register
  logic [pba_pkg::OUT_VAL_W-1:0] res_value_r;
  logic                          res_status_r;
  logic                          out_valid_r;
  logic [pba_pkg::OUT_VAL_W-1:0] out_value_r;
  logic                          out_status_r;

  // scan combinational signals
  logic signed [R_W:0]     r_s;
  logic signed [CO_W-1:0]  x_s;
  logic signed [CO_W-1:0]  y_s;
  logic [SQ_W:0]           d2;
  logic                    in_disk;
  logic                    in_grid;
  logic [SQ_W-1:0]         inc;
  logic [AW-1:0]           scan_addr;
  logic [VB:0]             sum;
  logic [VB-1:0]           sat_sum;

  // request position check
  logic                    pos_out;
  logic [R_W-1:0]          r_sq_in;

  // clamp configuration to the grid and radius limits
  always_comb begin
    r_eff = (int'(radius_r) > pba_pkg::MAX_RADIUS) ? R_W'(pba_pkg::MAX_RADIUS) : radius_r;
    w_eff = (int'(width_r) > pba_pkg::GRID_W) ? DIM_W'(pba_pkg::GRID_W) : width_r;
    h_eff = (int'(height_r) > pba_pkg::GRID_H) ? DIM_W'(pba_pkg::GRID_H) : height_r;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= pba_pkg::RADIUS_RST;
      width_r  <= pba_pkg::WIDTH_RST;
      height_r <= pba_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pba_pkg::CFG_RADIUS: radius_r <= cfg_wdata[R_W-1:0];
        pba_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        pba_pkg::CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read position check on the incoming request
  assign pos_out = pos_x[POS_W-1] || pos_y[POS_W-1] ||
                   !({1'b0, pos_x[POS_W-2:0]} < {1'b0, w_eff}) ||
                   !({1'b0, pos_y[POS_W-2:0]} < {1'b0, h_eff});
  assign r_sq_in = r_eff;

  // window offsets and distances
  assign r_s     = $signed({1'b0, r_r});
  assign x_s     = CO_W'(cx_r) + CO_W'(dx_r);
  assign y_s     = CO_W'(cy_r) + CO_W'(dy_r);
  assign d2      = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign in_disk = (d2 <= {1'b0, r2_r});
  assign in_grid = !x_s[CO_W-1] && (x_s[CO_W-2:0] < (CO_W-1)'(w_eff)) &&
                   !y_s[CO_W-1] && (y_s[CO_W-2:0] < (CO_W-1)'(h_eff));
  assign inc     = r2_r - d2[SQ_W-1:0];
  assign scan_addr = pba_pkg::cell_addr(y_s[pba_pkg::YI_W-1:0], x_s[pba_pkg::XI_W-1:0]);

  assign sts.scan_last  = (dx_r == r_s) && (dy_r == r_s);
  assign sts.clear_last = (clr_addr_r == AW'(pba_pkg::CELLS - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

  // request latch and window walk, row by row
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx_r       <= pos_x;
      cy_r       <= pos_y;
      r_r        <= r_eff;
      r2_r       <= SQ_W'(r_sq_in * r_sq_in);
      dx_r       <= -$signed({1'b0, r_eff});
      dy_r       <= -$signed({1'b0, r_eff});
      dx2_r      <= SQ_W'(r_sq_in * r_sq_in);
      dy2_r      <= SQ_W'(r_sq_in * r_sq_in);
      req_addr_r <= pba_pkg::cell_addr(pos_y[pba_pkg::YI_W-1:0], pos_x[pba_pkg::XI_W-1:0]);
    end else if (cmd.scan_step) begin
      if (dx_r == r_s) begin
        dx_r  <= -r_s;
        dx2_r <= r2_r;
        dy_r  <= dy_r + 1'b1;
        dy2_r <= pba_pkg::sq_next(dy2_r, dy_r);
      end else begin
        dx_r  <= dx_r + 1'b1;
        dx2_r <= pba_pkg::sq_next(dx2_r, dx_r);
      end
    end
  end

  // write stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= cmd.scan_step && in_disk && in_grid;
    end
  end

  always_ff @(posedge clk) begin
    p_addr_r <= scan_addr;
    p_inc_r  <= inc;
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // saturating add on the cell value read in the previous cycle
  assign sum     = {1'b0, rd_data_r} + (VB+1)'(p_inc_r);
  assign sat_sum = sum[VB] ? {VB{1'b1}} : sum[VB-1:0];

  assign rd_addr = cmd.scan_step ? scan_addr : req_addr_r;

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr_r] <= '0;
    end else if (p_valid_r) begin
      mem[p_addr_r] <= sat_sum;
    end
    rd_data_r <= mem[rd_addr];
  end

  // result hold
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_value_r  <= '0;
      res_status_r <= (pba_pkg::req_t'(req_type) == pba_pkg::REQ_READ) && pos_out;
    end else if (cmd.capture && !res_status_r) begin
      res_value_r <= rd_data_r[pba_pkg::OUT_VAL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

### src/paraboloid_bump_accumulator.sv
`timescale 1ns / 1ps

// channel | direction | transfer carries
// in_     | slave     | request: req_type, pos_x, pos_y
// out_    | master    | result: cell_value, status
// cfg_    | write     | radius (0), grid_width (1), grid_height (2)
//
// a bump walks its (2r+1) x (2r+1) window one cell a cycle through the
// read-modify-write pipe of the cell store; a clear sweeps every cell to zero
// after reset a clearing sweep of every cell runs before in_tready rises
// one request is worked at a time; a finished result waits in the output
// register while the next request is taken

module paraboloid_bump_accumulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write port
  input  logic                                 cfg_we,
  input  logic [pba_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [pba_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // request stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [pba_pkg::IN_TDATA_W-1:0]       in_tdata,  // req_type, pos_x, pos_y
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [pba_pkg::OUT_TDATA_W-1:0]      out_tdata  // cell_value, status
);

  localparam int POS_W = pba_pkg::POS_W;
  localparam int REQ_W = pba_pkg::REQ_W;

  pba_pkg::cmd_t cmd;
  pba_pkg::sts_t sts;

  logic [REQ_W-1:0]                 in_req_type;
  logic signed [POS_W-1:0]          in_pos_x;
  logic signed [POS_W-1:0]          in_pos_y;
  logic [pba_pkg::OUT_VAL_W-1:0]    out_cell_value;
  logic                             out_status;

  // request field unpacking
  assign in_req_type = in_tdata[REQ_W-1:0];
  assign in_pos_x    = in_tdata[REQ_W+POS_W-1:REQ_W];
  assign in_pos_y    = in_tdata[REQ_W+2*POS_W-1:REQ_W+POS_W];

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_type  (in_req_type),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .req_type   (in_req_type),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (out_cell_value),
    .out_status (out_status)
  );

  // result packing, zero padded to whole bytes
  assign out_tdata = {{(pba_pkg::OUT_TDATA_W - pba_pkg::OUT_VAL_W - 1){1'b0}},
                      out_status, out_cell_value};

endmodule

### src/pba_checker.sv
`timescale 1ns / 1ps

module pba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pba_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int VW = pba_pkg::OUT_VAL_W;

  // requests taken but not yet answered
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'((in_tvalid && in_tready) ? 1 : 0)
                       - 2'((out_tvalid && out_tready) ? 1 : 0);
    end
  end

  // no result while reset is held
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // every result answers a request
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> pend_r != 2'd0)
    else $error("result without request");

  // at most one request in work and one result waiting
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  // an out-of-grid read carries a zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[VW] |-> out_tdata[VW-1:0] == '0)
    else $error("status set with nonzero value");

endmodule

bind paraboloid_bump_accumulator pba_checker u_pba_checker (.*);

### dv/paraboloid_bump_accumulator_tb.sv
`timescale 1ns / 1ps

module paraboloid_bump_accumulator_tb;
  import pba_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SETTING_PHASES = 11;
  // register index that the block does not decode
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [VALUE_BITS-1:0] CELL_MAX = '1;

  // one expected result transfer
  typedef struct {
    logic [OUT_VAL_W-1:0] cell_value;
    logic                 status;
  } grid_result_t;

  // height grid predictor and result checker
  class height_model;
    logic [VALUE_BITS-1:0] cells [CELLS];
    logic [R_W-1:0]        radius;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    grid_result_t          pending_results [$];
    int mismatches;
    int results_seen;
    int bumps;
    int reads;
    int outside_reads;
    int clears;
    int ignored;

    function new();
      foreach (cells[i]) cells[i] = '0;
      radius     = RADIUS_RST;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
    endfunction

    function int used_cols();
      return (int'(width_reg) > GRID_W) ? GRID_W : int'(width_reg);
    endfunction

    function int used_rows();
      return (int'(height_reg) > GRID_H) ? GRID_H : int'(height_reg);
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_RADIUS: radius = value[R_W-1:0];
        CFG_WIDTH:  width_reg = value[DIM_W-1:0];
        CFG_HEIGHT: height_reg = value[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // add the paraboloid around (cx, cy), skipping cells outside the area in use
    function void raise_paraboloid(int cx, int cy);
      int r, r2, cols, rows, x, y, d2, idx;
      logic [VALUE_BITS-1:0] inc;
      r = (int'(radius) > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
      r2 = r * r;
      cols = used_cols();
      rows = used_rows();
      for (int dy = -r; dy <= r; dy++) begin
        y = cy + dy;
        if (y < 0 || y >= rows) continue;
        for (int dx = -r; dx <= r; dx++) begin
          x = cx + dx;
          d2 = dx * dx + dy * dy;
          if (x < 0 || x >= cols || d2 > r2) continue;
          inc = VALUE_BITS'(r2 - d2);
          idx = y * GRID_W + x;
          if (cells[idx] > CELL_MAX - inc) cells[idx] = CELL_MAX;
          else cells[idx] = cells[idx] + inc;
        end
      end
    endfunction

    // work out the result of an accepted request
    function void take_request(req_t kind, logic signed [POS_W-1:0] px,
                               logic signed [POS_W-1:0] py);
      grid_result_t res;
      int x, y;
      x = int'(px);
      y = int'(py);
      res.cell_value = '0;
      res.status = 1'b0;
      case (kind)
        REQ_BUMP: begin
          raise_paraboloid(x, y);
          bumps++;
        end
        REQ_READ: begin
          reads++;
          if (x < 0 || y < 0 || x >= used_cols() || y >= used_rows()) begin
            res.status = 1'b1;
            outside_reads++;
          end else begin
            res.cell_value = cells[y * GRID_W + x][OUT_VAL_W-1:0];
          end
        end
        REQ_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
          clears++;
        end
        default: ignored++;
      endcase
      pending_results.push_back(res);
    endfunction

    // compare a result transfer with the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] word);
      grid_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: cell_value %0d status %0d",
               word[OUT_VAL_W-1:0], word[OUT_VAL_W]);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (word[OUT_VAL_W-1:0] !== want.cell_value) begin
        $error("cell_value: expected %0d, got %0d", want.cell_value, word[OUT_VAL_W-1:0]);
        mismatches++;
      end
      if (word[OUT_VAL_W] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, word[OUT_VAL_W]);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;  // req_type, pos_x, pos_y
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // cell_value, status

  height_model grid_sb = new();
  bit steady;
  int stall_left;
  int cycle_count;

  paraboloid_bump_accumulator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle length: mostly none, some short, a few long
  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check each transfer, then stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) grid_sb.check_result(out_tdata);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = random_gap();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("paraboloid_bump_accumulator_tb NOT OK");
      $finish;
    end
  end

  // one request transfer, with an optional gap in front
  task automatic send_request(req_t kind, int px, int py);
    int gap;
    logic [POS_W-1:0] bx, by;
    bx = POS_W'(px);
    by = POS_W'(py);
    gap = random_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({by, bx, kind});
    do @(posedge clk); while (!in_tready);
    grid_sb.take_request(kind, bx, by);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    grid_sb.set_reg(idx, value);
  endtask

  // new register setting, spare index first; radius upper bits are junk
  task automatic apply_settings(int r, int cols, int rows);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_RADIUS, {2'($urandom), 5'(r)});
    write_reg(CFG_WIDTH, CFG_DATA_W'(cols));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(rows));
    cfg_we <= 1'b0;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (grid_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly positions in and around the area in use, some anywhere
  task automatic random_request();
    int roll, px, py;
    req_t kind;
    roll = $urandom_range(0, 99);
    if (roll < 45) kind = REQ_BUMP;
    else if (roll < 88) kind = REQ_READ;
    else if (roll < 94) kind = REQ_CLEAR;
    else kind = REQ_NONE;
    if ($urandom_range(0, 3) == 0) begin
      px = $urandom_range(0, 255);
      py = $urandom_range(0, 255);
    end else begin
      px = int'($urandom_range(0, grid_sb.used_cols() + 1)) - 1;
      py = int'($urandom_range(0, grid_sb.used_rows() + 1)) - 1;
    end
    send_request(kind, px, py);
  endtask

  // reset settings: radius 25 on the full 64 x 64 grid
  task automatic run_directed();
    send_request(REQ_READ, 0, 0);
    send_request(REQ_BUMP, 10, 10);
    send_request(REQ_READ, 10, 10);
    send_request(REQ_READ, 35, 10);
    send_request(REQ_READ, 10, 34);
    // centre far outside, nothing lands
    send_request(REQ_BUMP, -32, -32);
    send_request(REQ_BUMP, -20, 5);
    send_request(REQ_READ, 0, 5);
    send_request(REQ_BUMP, 127, 127);
    send_request(REQ_BUMP, 70, 63);
    send_request(REQ_READ, 63, 63);
    // reads off the edges of the grid
    send_request(REQ_READ, 64, 0);
    send_request(REQ_READ, 0, 64);
    send_request(REQ_READ, -1, 0);
    send_request(REQ_READ, -128, 127);
    send_request(REQ_READ, 127, -128);
    send_request(REQ_NONE, 8'h55, 8'hAA);
    send_request(REQ_READ, 45, 63);
    send_request(REQ_CLEAR, 8'hAA, 8'h55);
    send_request(REQ_READ, 10, 10);
    send_request(REQ_READ, 63, 63);
    send_request(REQ_BUMP, 0, 63);
    send_request(REQ_READ, 0, 63);
    send_request(REQ_NONE, -1, -1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    steady = 1'b0;
    stall_left = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    settle();

    // settings: zero radius, oversized grid, one cell, full radius, empty areas, random
    for (int p = 0; p < SETTING_PHASES; p++) begin
      case (p)
        0: apply_settings(0, 127, 127);
        1: apply_settings(1, 1, 1);
        2: apply_settings(MAX_RADIUS, 64, 64);
        3: apply_settings(3, 0, 9);
        4: apply_settings(5, 17, 0);
        default: apply_settings($urandom_range(1, 12), $urandom_range(1, 80),
                                $urandom_range(1, 80));
      endcase
      steady = (p % 4 == 2);
      repeat ((p == 2) ? 10 : 13) random_request();
      settle();
    end

    $display("covered %0d bumps, %0d reads (%0d outside), %0d clears, %0d ignored requests",
             grid_sb.bumps, grid_sb.reads, grid_sb.outside_reads, grid_sb.clears,
             grid_sb.ignored);
    $display("over %0d register settings, %0d results checked in %0d cycles",
             SETTING_PHASES + 1, grid_sb.results_seen, cycle_count);
    if (grid_sb.mismatches == 0 && grid_sb.pending_results.size() == 0) begin
      $display("paraboloid_bump_accumulator_tb OK");
    end else begin
      $display("paraboloid_bump_accumulator_tb NOT OK");
    end
    $finish;
  end

endmodule
